// ===== rtl/core/page_aligned_range_coalescer_core_assert.svh =====
// assertion macros for the range coalescer core
// expects clk and rst in the scope where the macros are used
`ifndef PAGE_ALIGNED_RANGE_COALESCER_CORE_ASSERT_SVH
`define PAGE_ALIGNED_RANGE_COALESCER_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PARC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PARC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/parc_pkg.sv =====
// shared types, codes and constants of the range coalescer core
// no dependencies
`default_nettype none

package parc_pkg;

  // field widths
  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 32;
  localparam int RLEN_W   = 33;
  localparam int PAGE_W   = 17;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;

  // remainder unit: dividend width and bits retired per cycle
  localparam int DIV_W     = 34;
  localparam int DIV_STEPS = 2;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam logic [PAGE_W-1:0] PAGE_RESET = 17'd256;
  localparam logic [DIV_W-1:0]  LEN_LIMIT  = 34'h1_0000_0000;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_APPENDED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [SLOT_W-1:0] entry_index;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  slot;
    logic [ADDR_W-1:0]  range_start;
    logic [RLEN_W-1:0]  range_length;
    logic [COUNT_W-1:0] entry_count;
  } result_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_READ_SCAN,
    OP_NEXT,
    OP_READ_IDX,
    OP_DIV_MERGE,
    OP_DIV_ADDR,
    OP_DIV_LEN,
    OP_WRITE_MERGE,
    OP_WRITE_APPEND,
    OP_EMIT_READ,
    OP_EMIT_FULL,
    OP_CLEAR,
    OP_EMIT_NONE
  } dp_op_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             hit;
    logic             scan_end;
    logic             full;
    logic             rem_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/parc_ram.sv =====
// generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module parc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] wr_addr,
  input  wire logic [W-1:0]                    wr_data,
  input  wire logic                            rd_en,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] rd_addr,
  output logic      [W-1:0]                    rd_data
);

  logic [W-1:0] mem [D];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/parc_rem.sv =====
// iterative remainder unit, two dividend bits per cycle
// depends on parc_pkg
`default_nettype none

module parc_rem
  import parc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [PAGE_W-1:0] divisor,
  output logic                   busy,
  output logic      [PAGE_W-1:0] remainder
);

  localparam int ITERS = DIV_W / DIV_STEPS;
  localparam int CNT_W = $clog2(ITERS + 1);

  logic [DIV_W-1:0]  shift;
  logic [DIV_W-1:0]  shift_next;
  logic [PAGE_W-1:0] rem_next;
  logic [CNT_W-1:0]  cnt;

  // restoring steps: shift in one dividend bit, subtract divisor if it fits
  always_comb begin
    logic [PAGE_W:0] t;
    shift_next = shift;
    rem_next   = remainder;
    for (int k = 0; k < DIV_STEPS; k++) begin
      t = {rem_next, shift_next[DIV_W-1]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      rem_next   = t[PAGE_W-1:0];
      shift_next = {shift_next[DIV_W-2:0], 1'b0};
    end
  end

  // iteration counter and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      shift     <= dividend;
      remainder <= '0;
      cnt       <= CNT_W'(ITERS);
    end else if (cnt != '0) begin
      shift     <= shift_next;
      remainder <= rem_next;
      cnt       <= cnt - 1'b1;
    end
  end

  assign busy = (cnt != '0);

endmodule

`default_nettype wire

// ===== rtl/core/parc_dp.sv =====
// datapath: range table RAM, page register, rounding and result register
// depends on parc_pkg, parc_ram, parc_rem
`default_nettype none

module parc_dp
  import parc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dp_op_t            op,
  output dp_status_t             st,
  input  wire request_t          request,
  input  wire logic              cfg_write,
  input  wire logic [PAGE_W-1:0] cfg_data,
  output logic                   done,
  output result_t                result
);

  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RAM_W = ADDR_W + RLEN_W;
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ENTRIES);

  logic [PAGE_W-1:0] page_bytes;
  logic [PAGE_W-1:0] page_eff;
  request_t          req;
  logic [CW-1:0]     scan_i;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_inc;
  logic [ADDR_W-1:0] seg_start;
  logic [RLEN_W-1:0] seg_len;
  logic [DIV_W-1:0]  dvd;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [RAM_W-1:0]  wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [RAM_W-1:0]  rd_data;
  logic [ADDR_W-1:0] ent_start;
  logic [RLEN_W-1:0] ent_len;

  logic              rem_start;
  logic [DIV_W-1:0]  rem_dvd;
  logic              rem_busy;
  logic [PAGE_W-1:0] remainder;

  logic [DIV_W-1:0]  merge_dvd;
  logic [DIV_W-1:0]  len_dvd;
  logic [DIV_W-1:0]  rounded;
  logic [RLEN_W-1:0] new_len;
  logic [RLEN_W-1:0] merged_len;
  logic              hit;
  logic              idx_ok;
  logic [AW-1:0]     scan_addr;
  logic [AW-1:0]     count_addr;
  logic [AW-1:0]     idx_addr;

  // narrow an index to the slot field
  function automatic logic [SLOT_W-1:0] to_slot(input logic [CW-1:0] v);
    logic [CW+SLOT_W-1:0] w;
    w = {{SLOT_W{1'b0}}, v};
    return w[SLOT_W-1:0];
  endfunction

  // narrow a count to the entry_count field
  function automatic logic [COUNT_W-1:0] to_count(input logic [CW-1:0] v);
    logic [CW+COUNT_W-1:0] w;
    w = {{COUNT_W{1'b0}}, v};
    return w[COUNT_W-1:0];
  endfunction

  // table addresses
  always_comb begin
    logic [CW+AW-1:0]     ws;
    logic [CW+AW-1:0]     wc;
    logic [SLOT_W+AW-1:0] wi;
    ws         = {{AW{1'b0}}, scan_i};
    wc         = {{AW{1'b0}}, count};
    wi         = {{AW{1'b0}}, req.entry_index};
    scan_addr  = ws[AW-1:0];
    count_addr = wc[AW-1:0];
    idx_addr   = wi[AW-1:0];
  end

  // a page size of zero means no rounding
  assign page_eff  = (page_bytes == '0) ? PAGE_W'(1) : page_bytes;
  assign count_inc = count + 1'b1;

  assign ent_start = rd_data[RAM_W-1:RLEN_W];
  assign ent_len   = rd_data[RLEN_W-1:0];

  // closed span test against the entry just read
  assign hit = (req.address >= ent_start) &&
               (({2'b00, ent_start} + {1'b0, ent_len}) >= {2'b00, req.address});

  // dividends for the rounding: value plus page minus one
  assign merge_dvd = {2'b00, req.address - ent_start} + {2'b00, req.length} +
                     {{(DIV_W-PAGE_W){1'b0}}, page_eff} - DIV_W'(1);
  assign len_dvd   = {2'b00, req.length} +
                     {{(DIV_W-PAGE_W){1'b0}}, page_eff} - DIV_W'(1);

  // round up by dropping the remainder, then saturate
  assign rounded    = dvd - {{(DIV_W-PAGE_W){1'b0}}, remainder};
  assign new_len    = (rounded > LEN_LIMIT) ? LEN_LIMIT[RLEN_W-1:0] : rounded[RLEN_W-1:0];
  assign merged_len = (new_len > seg_len) ? new_len : seg_len;

  assign idx_ok = ({{CW{1'b0}}, req.entry_index} < {{SLOT_W{1'b0}}, count});

  // RAM and remainder unit controls
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = scan_addr;
    wr_en     = 1'b0;
    wr_addr   = scan_addr;
    wr_data   = {seg_start, merged_len};
    rem_start = 1'b0;
    rem_dvd   = merge_dvd;
    case (op)
      OP_READ_SCAN: begin
        rd_en = 1'b1;
      end
      OP_READ_IDX: begin
        rd_en   = 1'b1;
        rd_addr = idx_addr;
      end
      OP_DIV_MERGE: begin
        rem_start = 1'b1;
      end
      OP_DIV_ADDR: begin
        rem_start = 1'b1;
        rem_dvd   = {2'b00, req.address};
      end
      OP_DIV_LEN: begin
        rem_start = 1'b1;
        rem_dvd   = len_dvd;
      end
      OP_WRITE_MERGE: begin
        wr_en = 1'b1;
      end
      OP_WRITE_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = count_addr;
        wr_data = {seg_start, new_len};
      end
      default: begin
      end
    endcase
  end

  // control registers: page size, count, scan index, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      page_bytes <= PAGE_RESET;
      count      <= '0;
      scan_i     <= '0;
      done       <= 1'b0;
    end else begin
      if (cfg_write) begin
        page_bytes <= cfg_data;
      end
      done <= 1'b0;
      case (op)
        OP_LOAD: begin
          scan_i <= '0;
        end
        OP_NEXT: begin
          scan_i <= scan_i + 1'b1;
        end
        OP_WRITE_APPEND: begin
          count <= count_inc;
          done  <= 1'b1;
        end
        OP_CLEAR: begin
          count <= '0;
          done  <= 1'b1;
        end
        OP_WRITE_MERGE, OP_EMIT_READ, OP_EMIT_FULL, OP_EMIT_NONE: begin
          done <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers: latched item, working entry, result
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        req <= request;
      end
      OP_DIV_MERGE: begin
        seg_start <= ent_start;
        seg_len   <= ent_len;
        dvd       <= merge_dvd;
      end
      OP_DIV_LEN: begin
        seg_start <= req.address - {{(ADDR_W-PAGE_W){1'b0}}, remainder};
        dvd       <= len_dvd;
      end
      OP_WRITE_MERGE: begin
        result <= '{status: ST_OK, slot: to_slot(scan_i), range_start: seg_start,
                    range_length: merged_len, entry_count: to_count(count)};
      end
      OP_WRITE_APPEND: begin
        result <= '{status: ST_APPENDED, slot: to_slot(count), range_start: seg_start,
                    range_length: new_len, entry_count: to_count(count_inc)};
      end
      OP_EMIT_READ: begin
        if (idx_ok) begin
          result <= '{status: ST_OK, slot: req.entry_index, range_start: ent_start,
                      range_length: ent_len, entry_count: to_count(count)};
        end else begin
          result <= '{status: ST_ABSENT, slot: req.entry_index, range_start: '0,
                      range_length: '0, entry_count: to_count(count)};
        end
      end
      OP_EMIT_FULL: begin
        result <= '{status: ST_FULL, slot: '0, range_start: '0,
                    range_length: '0, entry_count: to_count(count)};
      end
      OP_CLEAR: begin
        result <= '0;
      end
      OP_EMIT_NONE: begin
        result <= '{status: ST_OK, slot: '0, range_start: '0,
                    range_length: '0, entry_count: to_count(count)};
      end
      default: begin
      end
    endcase
  end

  // status back to the controller
  assign st.command  = req.command;
  assign st.hit      = hit;
  assign st.scan_end = (scan_i == count);
  assign st.full     = (count == MAX_COUNT);
  assign st.rem_busy = rem_busy;

  parc_ram #(
    .W (RAM_W),
    .D (MAX_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  parc_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (rem_dvd),
    .divisor   (page_eff),
    .busy      (rem_busy),
    .remainder (remainder)
  );

endmodule

`default_nettype wire

// ===== rtl/core/parc_ctrl.sv =====
// controller: sequences search, rounding, table update and result
// depends on parc_pkg
`default_nettype none

module parc_ctrl
  import parc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire dp_status_t st,
  output dp_op_t          op,
  output logic            busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_WAIT_MERGE,
    S_WAIT_ADDR,
    S_WAIT_LEN,
    S_READ_OUT
  } state_t;

  state_t state;
  state_t state_next;

  // next state and datapath operation
  always_comb begin
    state_next = state;
    op         = OP_IDLE;
    case (state)
      S_IDLE: begin
        if (start) begin
          op         = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.command)
          CMD_ADD: begin
            state_next = S_SCAN_RD;
          end
          CMD_READ: begin
            op         = OP_READ_IDX;
            state_next = S_READ_OUT;
          end
          CMD_CLEAR: begin
            op         = OP_CLEAR;
            state_next = S_IDLE;
          end
          default: begin
            op         = OP_EMIT_NONE;
            state_next = S_IDLE;
          end
        endcase
      end
      // read the next valid entry, or finish the search without a hit
      S_SCAN_RD: begin
        if (!st.scan_end) begin
          op         = OP_READ_SCAN;
          state_next = S_SCAN_CMP;
        end else if (st.full) begin
          op         = OP_EMIT_FULL;
          state_next = S_IDLE;
        end else begin
          op         = OP_DIV_ADDR;
          state_next = S_WAIT_ADDR;
        end
      end
      S_SCAN_CMP: begin
        if (st.hit) begin
          op         = OP_DIV_MERGE;
          state_next = S_WAIT_MERGE;
        end else begin
          op         = OP_NEXT;
          state_next = S_SCAN_RD;
        end
      end
      S_WAIT_MERGE: begin
        if (!st.rem_busy) begin
          op         = OP_WRITE_MERGE;
          state_next = S_IDLE;
        end
      end
      S_WAIT_ADDR: begin
        if (!st.rem_busy) begin
          op         = OP_DIV_LEN;
          state_next = S_WAIT_LEN;
        end
      end
      S_WAIT_LEN: begin
        if (!st.rem_busy) begin
          op         = OP_WRITE_APPEND;
          state_next = S_IDLE;
        end
      end
      S_READ_OUT: begin
        op         = OP_EMIT_READ;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/page_aligned_range_coalescer_core.sv =====
// top level of the page-aligned range coalescer
// depends on parc_pkg, parc_ctrl, parc_dp and the assertion macro header
`default_nettype none
`include "page_aligned_range_coalescer_core_assert.svh"

// An item is taken when start is high and busy is low; its single result
// appears on result for exactly one cycle with done high, and the receiver
// cannot hold it off, so it must capture the result in that cycle. Clear and
// the unused command pass through the dispatch state alone, a read also
// through the read-out state. An add searches the valid entries in order,
// reading each through the table RAM's registered read port, and each page
// rounding runs in the shared remainder unit (two bits per cycle over a
// 34-bit dividend): a merge needs one rounding, an append two (address and
// length), and a full table answers once all entries are searched. The page
// size may be written through the cfg channel whenever busy is low;
// cfg_ready follows !busy. There is no clearing pass after reset.
module page_aligned_range_coalescer_core
  import parc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire request_t          request,
  output logic                   done,
  output result_t                result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [PAGE_W-1:0] cfg_data
);

  dp_op_t     op;
  dp_status_t st;

  assign cfg_ready = !busy;

  parc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .op    (op),
    .busy  (busy)
  );

  parc_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .st        (st),
    .request   (request),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  // checks on the command sequencing
  `PARC_ASSERT_SAME(a_done_idle, done, !busy, "result given while still busy")
  `PARC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not start work")
  `PARC_ASSERT_SAME(a_busy_cause, $rose(busy), $past(start), "busy rose without an item")
  `PARC_ASSERT_NEXT(a_single_result, done, !done, "item gave more than one result")

endmodule

`default_nettype wire
